// ----- rtl/core/prm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_pkg: shared constants and types for the price return block
// Field widths, scale constants and the status codes.
// ----------------------------------------------------------------------------
package prm_pkg;
	localparam int PriceW   = 32;
	localparam int TsW      = 40;
	localparam int ChgW     = 33;
	localparam int PctW     = 48;
	localparam int LogW     = 30;
	localparam int StW      = 2;
	localparam int Log2Frac = 40;
	localparam int LogFracBitsDef = 24;
	localparam logic [31:0] Ln2Q32   = 32'd2977044472;
	localparam logic [22:0] PctScale = 23'd6553600;

	typedef enum logic [StW-1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
	} ctl_t;
endpackage

// ----- rtl/core/prm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_div: bit-serial restoring divider
// Divides a 55-bit magnitude by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prm_div
	import prm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic [54:0]       num,
	input  logic [PriceW-1:0] den,
	output logic              done,
	output logic [54:0]       quo
);
	logic [5:0]        cnt_q;
	logic              run_q;
	logic [32:0]       rem_q;
	logic [54:0]       q_q;
	logic [PriceW-1:0] den_q;
	logic [33:0]       trial;

	assign trial = {rem_q, q_q[54]} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			cnt_q <= 6'd0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd54) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (run_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				q_q   <= {q_q[53:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], q_q[54]};
				q_q   <= {q_q[53:0], 1'b0};
			end
		end
	end

	assign done = !run_q;
	assign quo  = q_q;
endmodule

// ----- rtl/core/prm_log2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_log2: serial log2 by repeated squaring
// Normalises the operand one bit a cycle, then yields one fraction bit per
// squaring cycle.
// ----------------------------------------------------------------------------
module prm_log2
	import prm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	input  logic [PriceW-1:0] x,
	output logic              done,
	output logic [Log2Frac+4:0] lg
);
	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR  = 3'b100
	} lstate_t;

	lstate_t           st_q;
	logic [32:0]       m_q;
	logic [4:0]        e_q;
	logic [5:0]        cnt_q;
	logic [Log2Frac-1:0] f_q;
	logic [63:0]       sq;
	logic [32:0]       ms;

	assign sq = {31'b0, m_q} * {31'b0, m_q};
	assign ms = sq[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= L_IDLE;
			cnt_q <= '0;
			e_q   <= '0;
		end else begin
			unique case (st_q)
				L_IDLE: if (ctl.start) begin
					st_q <= L_NORM;
					e_q  <= 5'd31;
				end
				L_NORM: begin
					if (m_q[31] || e_q == 5'd0) begin
						st_q  <= L_SQR;
						cnt_q <= '0;
					end else e_q <= e_q - 5'd1;
				end
				L_SQR: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(Log2Frac - 1)) st_q <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			L_IDLE: if (ctl.start) begin
				m_q <= {1'b0, x};
				f_q <= '0;
			end
			L_NORM: if (!(m_q[31] || e_q == 5'd0)) m_q <= {m_q[31:0], 1'b0};
			L_SQR: begin
				if (ms[32]) begin
					m_q <= {1'b0, ms[32:1]};
					f_q <= {f_q[Log2Frac-2:0], 1'b1};
				end else begin
					m_q <= ms;
					f_q <= {f_q[Log2Frac-2:0], 1'b0};
				end
			end
			default: m_q <= m_q;
		endcase
	end

	assign done = (st_q == L_IDLE) && !ctl.start;
	assign lg   = {e_q, f_q};
endmodule

// ----- rtl/core/price_return_metrics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_return_metrics: per-tick return figures of a price series
// Absolute change, percent changes and log return of each closing price.
// ----------------------------------------------------------------------------
// Input channel: close_price, series_start, timestamp on in_valid/in_ready.
// Output channel: timestamp_out, price_change, change_percent,
// cumulative_percent, log_return, status on out_valid/out_ready.
// One item is worked at a time. For a normal item, the two percent quotients
// run one after the other on a single bit-serial divider, the two log2 units
// (normalising, then 40 squaring steps) run alongside the divisions, and the
// log difference is then formed and scaled by ln2 in a registered multiply and
// add, after which the result is registered.
// Start-of-series and zero items have their result the cycle after acceptance.
// The result sits in an output register; the next item is taken in the cycle
// the result is handed over or later.
// Reset clears the stored first and previous prices and all handshakes.
// A stalled receiver holds the result and blocks new items.
// ----------------------------------------------------------------------------
module price_return_metrics
	import prm_pkg::*;
#(
	parameter int LOG_FRAC_BITS = LogFracBitsDef
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PriceW-1:0]        close_price,
	input  logic                     series_start,
	input  logic [TsW-1:0]           timestamp,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [TsW-1:0]           timestamp_out,
	output logic signed [ChgW-1:0]   price_change,
	output logic signed [PctW-1:0]   change_percent,
	output logic signed [PctW-1:0]   cumulative_percent,
	output logic signed [LogW-1:0]   log_return,
	output logic [StW-1:0]           status
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_GO   = 6'b000010,
		S_DIV1 = 6'b000100,
		S_DIV2 = 6'b001000,
		S_LOG  = 6'b010000,
		S_MUL  = 6'b100000
	} state_t;

	localparam int Shift = Log2Frac - LOG_FRAC_BITS;

	state_t            st_q;
	logic [PriceW-1:0] first_q, prev_q, cur_q;
	logic              sat_q;
	logic [PctW-1:0]   dp_q;
	ctl_t              dctl, lctl;
	logic [54:0]       dnum;
	logic [PriceW-1:0] dden;
	logic              ddone, adone, bdone;
	logic [54:0]       quo;
	logic [Log2Frac+4:0] la, lb;
	logic              lneg_q;
	logic [Log2Frac+4:0] d_q;
	logic [63:0]       bp_s1, ch_s1;
	logic [63:0]       c_s2;
	logic [1:0]        mstage_q;
	logic              ld_out;
	logic              take, fast;
	logic              neg1, neg2;
	logic [31:0]       mag1, mag2;
	logic [47:0]       q1, q2;
	logic              s2;
	logic [63:0]       r;
	logic [LogW-1:0]   rl, rmag;

	assign in_ready = (st_q == S_IDLE) && (!out_valid || out_ready);
	assign take = in_valid && in_ready;
	assign fast = series_start || close_price == '0 || prev_q == '0 || first_q == '0;

	assign neg1 = cur_q < prev_q;
	assign mag1 = neg1 ? prev_q - cur_q : cur_q - prev_q;
	assign neg2 = cur_q < first_q;
	assign mag2 = neg2 ? first_q - cur_q : cur_q - first_q;

	assign dctl.start = (st_q == S_GO) || (st_q == S_DIV1 && ddone);
	assign dnum = (st_q == S_GO) ? 55'(mag1) * 55'(PctScale)
		: 55'(mag2) * 55'(PctScale);
	assign dden = (st_q == S_GO) ? prev_q : first_q;
	assign lctl.start = (st_q == S_GO);

	prm_div u_div (.clk, .arst_n, .ctl(dctl), .num(dnum), .den(dden),
		.done(ddone), .quo);
	prm_log2 u_la (.clk, .arst_n, .ctl(lctl), .x(cur_q), .done(adone), .lg(la));
	prm_log2 u_lb (.clk, .arst_n, .ctl(lctl), .x(prev_q), .done(bdone), .lg(lb));

	// saturate a quotient magnitude with sign
	function automatic logic [48:0] sat48(input logic neg, input logic [54:0] q);
		logic [54:0] lim;
		logic        s;
		logic [47:0] v;
		lim = neg ? 55'h800000000000 : 55'h7FFFFFFFFFFF;
		s   = q > lim;
		v   = s ? lim[47:0] : q[47:0];
		v   = neg ? 48'(-v) : v;
		return {s, v};
	endfunction

	assign {s2, q2} = sat48(neg2, quo);
	assign q1 = dp_q;
	assign r  = c_s2 >> Shift;
	assign rl = lneg_q ? 30'h20000000 : 30'h1FFFFFFF;
	assign rmag = (r > 64'(rl)) ? rl : r[LogW-1:0];
	assign ld_out = (st_q == S_MUL) && mstage_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			out_valid <= 1'b0;
			first_q   <= '0;
			prev_q    <= '0;
			mstage_q  <= '0;
		end else begin
			if ((take && fast) || ld_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (take) begin
					cur_q         <= close_price;
					timestamp_out <= timestamp;
					if (series_start) first_q <= close_price;
					if (fast) begin
						prev_q             <= close_price;
						price_change       <= '0;
						change_percent     <= '0;
						cumulative_percent <= '0;
						log_return         <= '0;
						status <= (series_start && close_price != '0) ? ST_OK : ST_ZERO;
					end else begin
						st_q <= S_GO;
					end
				end
				S_GO: st_q <= S_DIV1;
				S_DIV1: if (ddone) begin
					{sat_q, dp_q} <= sat48(neg1, quo);
					st_q <= S_DIV2;
				end
				S_DIV2: if (ddone) begin
					cumulative_percent <= q2;
					sat_q <= sat_q | s2;
					st_q  <= S_LOG;
				end
				S_LOG: if (adone && bdone) begin
					lneg_q   <= la < lb;
					d_q      <= (la < lb) ? lb - la : la - lb;
					mstage_q <= '0;
					st_q     <= S_MUL;
				end
				S_MUL: begin
					mstage_q <= mstage_q + 2'd1;
					if (ld_out) begin
						price_change   <= ChgW'({1'b0, cur_q}) - ChgW'({1'b0, prev_q});
						change_percent <= q1;
						log_return     <= lneg_q ? -rmag : rmag;
						status <= sat_q ? ST_SAT : ST_OK;
						prev_q <= cur_q;
						st_q   <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		bp_s1 <= 64'(d_q[31:0]) * 64'(Ln2Q32);
		ch_s1 <= 64'(d_q[Log2Frac+4:32]) * 64'(Ln2Q32);
		c_s2  <= ch_s1 + (bp_s1 >> 32);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> st_q == S_IDLE)
		else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> !out_valid || out_ready)
		else $error("result overwritten");
endmodule
